// ----- hw/rtl/drrip_dead_block_replacement_unit_assert.svh -----
`ifndef DRRIP_DEAD_BLOCK_REPLACEMENT_UNIT_ASSERT_SVH
`define DRRIP_DEAD_BLOCK_REPLACEMENT_UNIT_ASSERT_SVH

// Clocked concurrent assertion, off while reset is asserted.
`define DRRIP_AST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Antecedent holds, consequent must hold in the next cycle.
`define DRRIP_AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `DRRIP_AST(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/drrip_pkg.sv -----
package drrip_pkg;

  localparam int RRPV_W     = 2;
  localparam int DEAD_W     = 2;
  localparam int THROTTLE_W = 5;
  localparam int DECAY_W    = 20;
  localparam int SET_IN_W   = 11;
  localparam int WAY_IN_W   = 4;
  localparam int MASK_W     = 16;
  localparam int REASON_W   = 2;

  localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
  localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
  localparam logic [DEAD_W-1:0] DEAD_ZERO    = 2'd0;
  localparam logic [DEAD_W-1:0] DEAD_MAX     = 2'd3;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 20'd100000;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic [REASON_W-1:0] REASON_INVALID = 2'd0;
  localparam logic [REASON_W-1:0] REASON_DEAD    = 2'd1;
  localparam logic [REASON_W-1:0] REASON_DISTANT = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } drrip_state_e;

  typedef struct packed {
    logic              sweep;
    logic              aging;
    logic [RRPV_W-1:0] age;
    logic              hit;
    logic [RRPV_W-1:0] miss_rrpv;
  } drrip_lane_ctl_t;

  typedef struct packed {
    logic              invalid;
    logic              dead;
    logic [RRPV_W-1:0] rrpv;
  } drrip_flag_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0] way;
    logic [REASON_W-1:0] reason;
    logic                aging;
    logic [RRPV_W-1:0]   age;
  } drrip_pick_t;

endpackage

// ----- hw/rtl/drrip_ram.sv -----
module drrip_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/drrip_lane.sv -----
module drrip_lane import drrip_pkg::*; (
  input  logic              [RRPV_W-1:0] rrpv_i,
  input  logic              [DEAD_W-1:0] dead_i,
  input  logic                           valid_i,
  input  logic                           sel_i,
  input  drrip_lane_ctl_t                ctl_i,
  output drrip_flag_t                    flag_o,
  output logic              [RRPV_W-1:0] rrpv_o,
  output logic              [DEAD_W-1:0] dead_o
);

  logic [DEAD_W-1:0] dead_up;

  assign flag_o.invalid = !valid_i;
  assign flag_o.dead    = (dead_i == DEAD_MAX);
  assign flag_o.rrpv    = rrpv_i;

  assign dead_up = (dead_i == DEAD_MAX) ? DEAD_MAX : dead_i + 1'b1;

  always_comb begin
    rrpv_o = rrpv_i;
    dead_o = dead_i;
    if (ctl_i.sweep) begin
      if (dead_i != DEAD_ZERO) begin
        dead_o = dead_i - 1'b1;
      end
    end else if (sel_i) begin
      if (ctl_i.hit) begin
        if (dead_i != DEAD_ZERO) begin
          dead_o = dead_i - 1'b1;
        end
        rrpv_o = RRPV_NEAR;
      end else begin
        dead_o = dead_up;
        rrpv_o = (dead_up == DEAD_MAX) ? RRPV_DISTANT : ctl_i.miss_rrpv;
      end
    end else if (ctl_i.aging) begin
      rrpv_o = rrpv_i + ctl_i.age;
    end
  end

endmodule

// ----- hw/rtl/drrip_merge.sv -----
module drrip_merge import drrip_pkg::*; #(
  parameter int NUM_WAYS = 16
) (
  input  drrip_flag_t flag_i [NUM_WAYS],
  output drrip_pick_t pick_o
);

  always_comb begin
    logic              found_inv;
    logic              found_dead;
    logic [RRPV_W-1:0] top;
    logic [WAY_IN_W-1:0] way_inv;
    logic [WAY_IN_W-1:0] way_dead;
    logic [WAY_IN_W-1:0] way_top;
    found_inv  = 1'b0;
    found_dead = 1'b0;
    top        = RRPV_NEAR;
    way_inv    = '0;
    way_dead   = '0;
    way_top    = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (flag_i[w].invalid) begin
        found_inv = 1'b1;
        way_inv   = WAY_IN_W'(w);
      end
      if (flag_i[w].dead) begin
        found_dead = 1'b1;
        way_dead   = WAY_IN_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (flag_i[w].rrpv > top) begin
        top = flag_i[w].rrpv;
      end
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (flag_i[w].rrpv == top) begin
        way_top = WAY_IN_W'(w);
      end
    end
    pick_o.age   = RRPV_DISTANT - top;
    pick_o.aging = !found_inv && !found_dead;
    if (found_inv) begin
      pick_o.way    = way_inv;
      pick_o.reason = REASON_INVALID;
    end else if (found_dead) begin
      pick_o.way    = way_dead;
      pick_o.reason = REASON_DEAD;
    end else begin
      pick_o.way    = way_top;
      pick_o.reason = REASON_DISTANT;
    end
  end

endmodule

// ----- hw/rtl/drrip_dead_block_replacement_unit.sv -----
// Query: the input word and its set row read from the state memory are registered,
//   then the victim is picked and the result word is registered.
// A new word is taken only after the previous one has finished the read-then-write-back of its set row.
// An update that triggers a decay sweep holds input off until the sweep has passed over every set.
// Reset: control clears at once, then a clearing pass over every set
//   initializes the state memory; input is held off until it completes.
module drrip_dead_block_replacement_unit import drrip_pkg::*; #(
  parameter int NUM_SETS     = 2048,
  parameter int NUM_WAYS     = 16,
  parameter int LEADER_SETS  = 64,
  parameter int SELECT_WIDTH = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // set_index, way_index, hit, valid_mask
  input  logic [0:0]         s_axis_tuser,  // kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // victim_way, victim_reason
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [DECAY_W-1:0] cfg_data_i
);

  localparam int SETW = $clog2(NUM_SETS);
  localparam int ROWW = NUM_WAYS * (RRPV_W + DEAD_W);
  localparam logic [ROWW-1:0] CLR_ROW = {NUM_WAYS{DEAD_ZERO, RRPV_LONG}};
  localparam logic [SETW:0] CNT_LAST = (SETW + 1)'(NUM_SETS - 1);
  localparam logic [SETW:0] CNT_END  = (SETW + 1)'(NUM_SETS);
  localparam logic [SELECT_WIDTH-1:0] SEL_MID = {1'b1, {(SELECT_WIDTH - 1){1'b0}}};
  localparam logic [SELECT_WIDTH-1:0] SEL_MAX = '1;

  logic [SET_IN_W-1:0] in_set;
  logic [WAY_IN_W-1:0] in_way;
  logic                in_hit;
  logic [MASK_W-1:0]   in_mask;
  logic                in_kind;
  logic [SETW-1:0]     in_set_map;
  logic                in_wok;
  logic                in_acc;

  logic [SETW-1:0]     it_set_q;
  logic [WAY_IN_W-1:0] it_way_q;
  logic                it_hit_q;
  logic [MASK_W-1:0]   it_mask_q;
  logic                it_kind_q;
  logic                it_wok_q;

  drrip_state_e state_q, state_d;
  logic [SETW:0] cnt_q, cnt_d, cnt_m1;

  logic [SELECT_WIDTH-1:0] psel_q, psel_d;
  logic [THROTTLE_W-1:0]   thr_q, thr_next;
  logic [DECAY_W-1:0]      dc_q, dc_next;
  logic [DECAY_W-1:0]      period_q;
  logic                    decay_fire;

  logic                srrip_lead, brrip_lead, brrip_mode;
  drrip_lane_ctl_t     lane_ctl;
  drrip_flag_t         flags [NUM_WAYS];
  drrip_pick_t         pick;

  logic            mem_we, mem_re;
  logic [SETW-1:0] mem_waddr, mem_raddr;
  logic [ROWW-1:0] mem_wdata, rd_row, new_row;
  logic            clr_row;

  logic                out_valid_q;
  logic [WAY_IN_W-1:0] out_way_q;
  logic [REASON_W-1:0] out_reason_q;
  logic                load_out, commit;

  assign in_set  = s_axis_tdata[10:0];
  assign in_way  = s_axis_tdata[14:11];
  assign in_hit  = s_axis_tdata[15];
  assign in_mask = s_axis_tdata[31:16];
  assign in_kind = s_axis_tuser[0];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_wok  = (32'(in_way) < NUM_WAYS);

  always_comb begin
    logic [SET_IN_W-1:0] v;
    v = in_set;
    for (int s = 3; s >= 0; s--) begin
      if (32'(v) >= (NUM_SETS << s)) begin
        v = v - SET_IN_W'(NUM_SETS << s);
      end
    end
    in_set_map = SETW'(v);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      it_set_q  <= in_set_map;
      it_way_q  <= in_way;
      it_hit_q  <= in_hit;
      it_mask_q <= in_mask;
      it_kind_q <= in_kind;
      it_wok_q  <= in_wok;
    end
  end

  assign srrip_lead = (32'(it_set_q) < LEADER_SETS);
  assign brrip_lead = !srrip_lead && (32'(it_set_q) >= NUM_SETS - LEADER_SETS);
  assign brrip_mode = srrip_lead ? 1'b0 : (brrip_lead ? 1'b1 : (psel_q < SEL_MID));
  assign thr_next   = thr_q + 1'b1;
  assign dc_next    = dc_q + 1'b1;
  assign decay_fire = (dc_next >= period_q);

  always_comb begin
    psel_d = psel_q;
    if (srrip_lead) begin
      if (it_hit_q && psel_q != SEL_MAX) begin
        psel_d = psel_q + 1'b1;
      end else if (!it_hit_q && psel_q != '0) begin
        psel_d = psel_q - 1'b1;
      end
    end else if (brrip_lead) begin
      if (it_hit_q && psel_q != '0) begin
        psel_d = psel_q - 1'b1;
      end else if (!it_hit_q && psel_q != SEL_MAX) begin
        psel_d = psel_q + 1'b1;
      end
    end
  end

  for (genvar w = 0; w < NUM_WAYS; w++) begin : g_lane
    logic vld;
    logic sel;
    if (w < MASK_W) begin : g_mask
      assign vld = it_mask_q[w];
    end else begin : g_nomask
      assign vld = 1'b1;
    end
    assign sel = (it_kind_q == KIND_UPDATE) && it_wok_q &&
                 ({1'b0, it_way_q} == (WAY_IN_W + 1)'(w));
    drrip_lane u_lane (
      .rrpv_i  (rd_row[4*w +: RRPV_W]),
      .dead_i  (rd_row[4*w+RRPV_W +: DEAD_W]),
      .valid_i (vld),
      .sel_i   (sel),
      .ctl_i   (lane_ctl),
      .flag_o  (flags[w]),
      .rrpv_o  (new_row[4*w +: RRPV_W]),
      .dead_o  (new_row[4*w+RRPV_W +: DEAD_W])
    );
  end

  drrip_merge #(
    .NUM_WAYS (NUM_WAYS)
  ) u_merge (
    .flag_i (flags),
    .pick_o (pick)
  );

  drrip_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROWW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_row)
  );

  assign cnt_m1    = cnt_q - 1'b1;
  assign mem_wdata = clr_row ? CLR_ROW : new_row;

  always_comb begin
    state_d            = state_q;
    cnt_d              = cnt_q;
    s_axis_tready      = 1'b0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_waddr          = it_set_q;
    mem_raddr          = in_set_map;
    clr_row            = 1'b0;
    load_out           = 1'b0;
    commit             = 1'b0;
    lane_ctl.sweep     = 1'b0;
    lane_ctl.aging     = 1'b0;
    lane_ctl.age       = pick.age;
    lane_ctl.hit       = it_hit_q;
    lane_ctl.miss_rrpv = (brrip_mode && thr_next != '0) ? RRPV_DISTANT : RRPV_LONG;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[SETW-1:0];
        clr_row   = 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mem_re  = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (it_kind_q == KIND_QUERY) begin
          if (!out_valid_q || m_axis_tready) begin
            lane_ctl.aging = pick.aging;
            mem_we         = 1'b1;
            load_out       = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
          if (it_wok_q) begin
            mem_we = 1'b1;
            commit = 1'b1;
            if (decay_fire) begin
              cnt_d   = '0;
              state_d = ST_SWEEP;
            end
          end
        end
      end
      ST_SWEEP: begin
        lane_ctl.sweep = 1'b1;
        mem_raddr      = cnt_q[SETW-1:0];
        mem_re         = (cnt_q < CNT_END);
        mem_we         = (cnt_q != '0);
        mem_waddr      = cnt_m1[SETW-1:0];
        if (cnt_q == CNT_END) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psel_q <= SEL_MID;
      thr_q  <= '0;
      dc_q   <= '0;
    end else if (commit) begin
      psel_q <= psel_d;
      thr_q  <= thr_next;
      dc_q   <= decay_fire ? '0 : dc_next;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= DECAY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_way_q    <= pick.way;
      out_reason_q <= pick.reason;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_reason_q, out_way_q};

endmodule

// ----- hw/rtl/drrip_chk.sv -----
`include "drrip_dead_block_replacement_unit_assert.svh"

module drrip_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [0:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  `DRRIP_AST_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
  `DRRIP_AST_NEXT(a_in_gap, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input word taken on back-to-back cycles")
  `DRRIP_AST(a_reason_code, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[5:4] != 2'd3), "victim reason out of range")
  `DRRIP_AST(a_query_result, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid) |-> ##2 m_axis_tvalid, "query gave no result word")
  `DRRIP_AST(a_update_silent, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid) |-> ##2 !m_axis_tvalid, "update produced a result word")

endmodule

bind drrip_dead_block_replacement_unit drrip_chk u_chk (.*);
